### design/lts_pkg.sv
// ----------------------------------------------------------------------------
// lts_pkg: shared types and constants of the Laplacian tridiagonal solver
// Holds the command format, result codes, controller states and the small
// arithmetic helpers used by the front and back parts.
// ----------------------------------------------------------------------------
package lts_pkg;

	// Fixed-point constants in unsigned Q2.30.
	localparam logic [31:0] Q30_ONE = 32'h4000_0000;
	localparam logic [31:0] Q30_TWO = 32'h8000_0000;

	// Result kinds.
	localparam logic [1:0] KIND_DONE    = 2'd0;
	localparam logic [1:0] KIND_DATA    = 2'd1;
	localparam logic [1:0] KIND_INVALID = 2'd2;

	// Command queue between front and back.
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = 2;

	// Divider: 64-bit magnitude shifted up by 30 bits, one quotient bit a cycle.
	localparam int DIV_STEPS = 94;
	localparam int DIV_CNT_W = 7;

	typedef enum logic [1:0] {
		CMD_LOAD,
		CMD_LOAD_LAST,
		CMD_READ
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t   kind;
		logic [31:0] sample;
		logic [9:0]  read_index;
	} cmd_t;

	typedef struct packed {
		logic        start;
		logic [63:0] x;
		logic        neg;
		logic [31:0] d;
	} div_req_t;

	typedef enum logic [3:0] {
		B_IDLE,
		B_RD0,
		B_CAP0,
		B_FP,
		B_FPW,
		B_FX,
		B_FXW,
		B_LAST,
		B_LASTW,
		B_BW1,
		B_BX,
		B_BXW,
		B_DONE,
		B_RW,
		B_RO
	} back_state_t;

	// Pivots below 1.0 are treated as 1.0.
	function automatic logic [31:0] clamp_pivot(input logic [31:0] d);
		clamp_pivot = (d < Q30_ONE) ? Q30_ONE : d;
	endfunction

	// Saturating signed 64-bit addition.
	function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
		logic [63:0] s;
		s = a + b;
		if (a[63] == b[63] && s[63] != a[63])
			sat_add = a[63] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
		else
			sat_add = s;
	endfunction

endpackage

### design/lts_front.sv
// ----------------------------------------------------------------------------
// lts_front: request intake and command queue
// Accepts requests, classifies them into load, final load or read commands
// and buffers them in a short queue for the back part.
// ----------------------------------------------------------------------------
module lts_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [47:0]      s_tdata,   // [31:0] sample, [41:32] read_index
	input  logic             s_tlast,   // final_sample
	input  logic             s_tuser,   // mode
	output logic             cmd_valid,
	input  logic             cmd_ready,
	output lts_pkg::cmd_t    cmd
);

	lts_pkg::cmd_t            queue_q [lts_pkg::QUEUE_DEPTH];
	logic [lts_pkg::QPTR_W-1:0] wr_ptr_q;
	logic [lts_pkg::QPTR_W-1:0] rd_ptr_q;
	logic [lts_pkg::QPTR_W:0]   count_q;
	lts_pkg::cmd_t            in_cmd;
	logic                     push;
	logic                     pop;

	// Classify the incoming request.
	always_comb begin
		in_cmd.sample     = s_tdata[31:0];
		in_cmd.read_index = s_tdata[41:32];
		if (s_tuser)
			in_cmd.kind = lts_pkg::CMD_READ;
		else if (s_tlast)
			in_cmd.kind = lts_pkg::CMD_LOAD_LAST;
		else
			in_cmd.kind = lts_pkg::CMD_LOAD;
	end

	assign s_tready  = (count_q != (lts_pkg::QPTR_W+1)'(lts_pkg::QUEUE_DEPTH));
	assign cmd_valid = (count_q != '0);
	assign cmd       = queue_q[rd_ptr_q];
	assign push      = s_tvalid && s_tready;
	assign pop       = cmd_valid && cmd_ready;

	// Queue storage.
	always_ff @(posedge clk) begin
		if (push)
			queue_q[wr_ptr_q] <= in_cmd;
	end

	// Queue pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

### design/lts_div.sv
// ----------------------------------------------------------------------------
// lts_div: serial fixed-point divider
// Computes x * 2^30 / max(d, 1.0), truncated toward zero, one quotient bit
// per cycle, with the sign applied to the magnitude quotient at the end.
// ----------------------------------------------------------------------------
module lts_div (
	input  logic              clk,
	input  logic              arst_n,
	input  lts_pkg::div_req_t req,
	output logic              busy,
	output logic              done,
	output logic [63:0]       result
);

	logic [93:0]                   dvd_q;
	logic [31:0]                   rem_q;
	logic [63:0]                   quo_q;
	logic [31:0]                   d_q;
	logic                          neg_q;
	logic                          busy_q;
	logic                          done_q;
	logic [lts_pkg::DIV_CNT_W-1:0] cnt_q;
	logic [32:0]                   trial;
	logic                          fits;
	logic [63:0]                   mag;

	assign mag   = req.neg ? (64'd0 - req.x) : req.x;
	assign trial = {rem_q, dvd_q[93]};
	assign fits  = (trial >= {1'b0, d_q});

	assign busy   = busy_q;
	assign done   = done_q;
	assign result = neg_q ? (64'd0 - quo_q) : quo_q;

	// Datapath: restoring division step.
	always_ff @(posedge clk) begin
		if (req.start && !busy_q) begin
			dvd_q <= {mag, 30'd0};
			rem_q <= '0;
			quo_q <= '0;
			d_q   <= lts_pkg::clamp_pivot(req.d);
			neg_q <= req.neg;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[92:0], 1'b0};
			rem_q <= fits ? 32'(trial - {1'b0, d_q}) : trial[31:0];
			quo_q <= {quo_q[62:0], fits};
		end
	end

	// Step counter and handshake.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == lts_pkg::DIV_CNT_W'(lts_pkg::DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule

### design/lts_back.sv
// ----------------------------------------------------------------------------
// lts_back: solve sequencer with vector memories
// Stores samples, runs the pivot recurrence, forward elimination and back
// substitution through one shared divider, and serves readback requests.
// ----------------------------------------------------------------------------
module lts_back #(
	parameter int MAX_LEN = 1024
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	output logic          cmd_ready,
	input  lts_pkg::cmd_t cmd,
	output logic          m_tvalid,
	input  logic          m_tready,
	output logic [87:0]   m_tdata,
	output logic [1:0]    m_tuser
);

	localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
	localparam int CW = $clog2(MAX_LEN + 1);

	lts_pkg::back_state_t state_q, state_d;

	logic [63:0] sol_mem [MAX_LEN];
	logic [31:0] pv_mem  [MAX_LEN];
	logic [63:0] sol_rd_q;
	logic [31:0] pv_rd_q;

	logic          sol_we;
	logic [AW-1:0] sol_wa;
	logic [63:0]   sol_wd;
	logic          pv_we;
	logic [AW-1:0] pv_wa;
	logic [31:0]   pv_wd;

	logic [CW-1:0] cnt_q;
	logic [CW-1:0] cnt_inc;
	logic [CW-1:0] slen_q;
	logic [CW-1:0] n_q;
	logic          valid_q;
	logic [AW-1:0] addr_q;
	logic [AW-1:0] i_q;
	logic [9:0]    idx_q;
	logic [63:0]   prev_x_q;
	logic [31:0]   prev_d_q;
	logic [31:0]   nd_q;
	logic [63:0]   b_q;
	logic [63:0]   cur_q;
	logic [63:0]   back_sum;
	logic [63:0]   fwd_sum;
	logic          i_last;
	logic          read_ok;
	logic [31:0]   slen32;
	logic [31:0]   n32;

	logic        out_valid_q;
	logic [1:0]  out_kind_q;
	logic [63:0] out_value_q;
	logic [9:0]  out_eidx_q;
	logic [10:0] out_vlen_q;
	logic        out_free;
	logic        out_load;

	lts_pkg::div_req_t div_req;
	logic              div_busy;
	logic              div_done;
	logic [63:0]       div_res;

	lts_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.busy   (div_busy),
		.done   (div_done),
		.result (div_res)
	);

	assign cnt_inc  = (cnt_q < CW'(MAX_LEN)) ? cnt_q + 1'b1 : cnt_q;
	assign back_sum = lts_pkg::sat_add(sol_rd_q, cur_q);
	assign fwd_sum  = lts_pkg::sat_add(b_q, div_res);
	assign i_last   = ((CW'(i_q) + CW'(1)) == n_q);
	assign slen32   = 32'(slen_q);
	assign n32      = 32'(n_q);
	assign read_ok  = valid_q && (32'(idx_q) < slen32);
	assign out_free = !out_valid_q || m_tready;

	// Vector memories with registered read.
	always_ff @(posedge clk) begin
		if (sol_we)
			sol_mem[sol_wa] <= sol_wd;
		if (pv_we)
			pv_mem[pv_wa] <= pv_wd;
		sol_rd_q <= sol_mem[addr_q];
		pv_rd_q  <= pv_mem[addr_q];
	end

	// Next-state logic.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			lts_pkg::B_IDLE: begin
				if (cmd_valid) begin
					if (cmd.kind == lts_pkg::CMD_READ)
						state_d = lts_pkg::B_RW;
					else if (cmd.kind == lts_pkg::CMD_LOAD_LAST)
						state_d = lts_pkg::B_RD0;
				end
			end
			lts_pkg::B_RD0:  state_d = lts_pkg::B_CAP0;
			lts_pkg::B_CAP0: state_d = (n_q == CW'(1)) ? lts_pkg::B_LAST : lts_pkg::B_FP;
			lts_pkg::B_FP:   state_d = lts_pkg::B_FPW;
			lts_pkg::B_FPW:  if (div_done) state_d = lts_pkg::B_FX;
			lts_pkg::B_FX:   state_d = lts_pkg::B_FXW;
			lts_pkg::B_FXW: begin
				if (div_done)
					state_d = i_last ? lts_pkg::B_LAST : lts_pkg::B_FP;
			end
			lts_pkg::B_LAST: state_d = lts_pkg::B_LASTW;
			lts_pkg::B_LASTW: begin
				if (div_done)
					state_d = (n_q == CW'(1)) ? lts_pkg::B_DONE : lts_pkg::B_BW1;
			end
			lts_pkg::B_BW1: state_d = lts_pkg::B_BX;
			lts_pkg::B_BX:  state_d = lts_pkg::B_BXW;
			lts_pkg::B_BXW: begin
				if (div_done)
					state_d = (addr_q == '0) ? lts_pkg::B_DONE : lts_pkg::B_BW1;
			end
			lts_pkg::B_DONE: if (out_free) state_d = lts_pkg::B_IDLE;
			lts_pkg::B_RW:   state_d = lts_pkg::B_RO;
			lts_pkg::B_RO:   if (out_free) state_d = lts_pkg::B_IDLE;
			default:         state_d = lts_pkg::B_IDLE;
		endcase
	end

	// Output logic: memory writes, divider requests, command pop, result load.
	always_comb begin
		cmd_ready = (state_q == lts_pkg::B_IDLE);
		sol_we    = 1'b0;
		sol_wa    = i_q;
		sol_wd    = div_res;
		pv_we     = 1'b0;
		pv_wa     = i_q;
		pv_wd     = nd_q;
		div_req   = '{start: 1'b0, x: prev_x_q, neg: prev_x_q[63], d: prev_d_q};
		out_load  = 1'b0;
		unique case (state_q)
			lts_pkg::B_IDLE: begin
				if (cmd_valid && cmd.kind != lts_pkg::CMD_READ &&
				    cnt_q < CW'(MAX_LEN)) begin
					sol_we = 1'b1;
					sol_wa = cnt_q[AW-1:0];
					sol_wd = {{32{cmd.sample[31]}}, cmd.sample};
				end
			end
			lts_pkg::B_RD0: begin
				pv_we = 1'b1;
				pv_wa = '0;
				pv_wd = lts_pkg::Q30_TWO;
			end
			lts_pkg::B_FP: begin
				div_req.start = 1'b1;
				div_req.x     = {31'd0, lts_pkg::clamp_pivot(prev_d_q), 1'b0}
				                - 64'(lts_pkg::Q30_ONE);
				div_req.neg   = 1'b0;
			end
			lts_pkg::B_FX, lts_pkg::B_LAST: begin
				div_req.start = 1'b1;
			end
			lts_pkg::B_FXW: begin
				if (div_done) begin
					sol_we = 1'b1;
					sol_wd = fwd_sum;
					pv_we  = 1'b1;
				end
			end
			lts_pkg::B_LASTW: begin
				sol_we = div_done;
			end
			lts_pkg::B_BX: begin
				div_req.start = 1'b1;
				div_req.x     = back_sum;
				div_req.neg   = back_sum[63];
				div_req.d     = pv_rd_q;
			end
			lts_pkg::B_BXW: begin
				sol_we = div_done;
				sol_wa = addr_q;
			end
			lts_pkg::B_DONE, lts_pkg::B_RO: begin
				out_load = out_free;
			end
			default: begin
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= lts_pkg::B_IDLE;
			cnt_q       <= '0;
			slen_q      <= '0;
			valid_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == lts_pkg::B_IDLE && cmd_valid &&
			    cmd.kind != lts_pkg::CMD_READ) begin
				if (cnt_q == '0) begin
					valid_q <= 1'b0;
					slen_q  <= '0;
				end
				cnt_q <= (cmd.kind == lts_pkg::CMD_LOAD_LAST) ? '0 : cnt_inc;
			end
			if (state_q == lts_pkg::B_DONE && out_free) begin
				slen_q  <= n_q;
				valid_q <= 1'b1;
			end
			if (out_load)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;
		end
	end

	// Datapath registers of the sweeps.
	always_ff @(posedge clk) begin
		unique case (state_q)
			lts_pkg::B_IDLE: begin
				if (cmd_valid) begin
					idx_q  <= cmd.read_index;
					addr_q <= (cmd.kind == lts_pkg::CMD_READ) ? AW'(cmd.read_index) : '0;
					n_q    <= cnt_inc;
				end
			end
			lts_pkg::B_CAP0: begin
				prev_x_q <= sol_rd_q;
				prev_d_q <= lts_pkg::Q30_TWO;
				i_q      <= (n_q == CW'(1)) ? '0 : AW'(1);
				addr_q   <= AW'(1);
			end
			lts_pkg::B_FPW: begin
				if (div_done) begin
					nd_q <= div_res[31:0];
					b_q  <= sol_rd_q;
				end
			end
			lts_pkg::B_FXW: begin
				if (div_done) begin
					prev_x_q <= fwd_sum;
					prev_d_q <= nd_q;
					if (!i_last) begin
						i_q    <= i_q + 1'b1;
						addr_q <= i_q + 1'b1;
					end
				end
			end
			lts_pkg::B_LASTW: begin
				if (div_done) begin
					cur_q  <= div_res;
					addr_q <= i_q - 1'b1;
				end
			end
			lts_pkg::B_BXW: begin
				if (div_done) begin
					cur_q <= div_res;
					if (addr_q != '0)
						addr_q <= addr_q - 1'b1;
				end
			end
			lts_pkg::B_DONE: begin
				if (out_free) begin
					out_kind_q  <= lts_pkg::KIND_DONE;
					out_value_q <= '0;
					out_eidx_q  <= '0;
					out_vlen_q  <= n32[10:0];
				end
			end
			lts_pkg::B_RO: begin
				if (out_free) begin
					out_kind_q  <= read_ok ? lts_pkg::KIND_DATA : lts_pkg::KIND_INVALID;
					out_value_q <= read_ok ? sol_rd_q : '0;
					out_eidx_q  <= idx_q;
					out_vlen_q  <= slen32[10:0];
				end
			end
			default: begin
			end
		endcase
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_kind_q;
	assign m_tdata  = {3'd0, out_vlen_q, out_eidx_q, out_value_q};

	// The shared divider is never restarted while it is still working.
	a_div_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_req.start |-> !div_busy)
		else $error("divider started while busy");

	// A divider result only arrives while the sequencer waits for one.
	a_div_done_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == lts_pkg::B_FPW || state_q == lts_pkg::B_FXW ||
		              state_q == lts_pkg::B_LASTW || state_q == lts_pkg::B_BXW))
		else $error("divider result arrived outside a wait state");

	// A solve always works on at least one element.
	a_solve_len: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == lts_pkg::B_CAP0 || state_q == lts_pkg::B_LAST) |-> (n_q != '0))
		else $error("solve started on an empty vector");

	// Commands are taken only while the sequencer is idle.
	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_valid && cmd_ready) |=> (state_q == lts_pkg::B_IDLE ||
		                              state_q == lts_pkg::B_RD0 || state_q == lts_pkg::B_RW))
		else $error("command taken outside the idle state");

endmodule

### design/laplacian_tridiagonal_solver.sv
// ----------------------------------------------------------------------------
// laplacian_tridiagonal_solver: Thomas solver for tridiag(-1, 2, -1) x = b
// Loads Q16.16 right-hand-side samples, solves in Q48.16 with Q2.30 pivots,
// and reads back solution elements by index.
// ----------------------------------------------------------------------------
// Channel   Dir  Signals                      Content
// s_        in   tvalid tready tdata tlast tuser  tdata: sample, read_index;
//                                                 tlast: final_sample; tuser: mode
// m_        out  tvalid tready tdata tuser        tdata: value, element_index,
//                                                 vector_length; tuser: kind
//
// A solve runs on the single serial divider, which does two divisions per element
// forward and one back.
// Reset clears the controller and the queue; the vector memories hold no reset.
// A four-entry command queue keeps taking requests while a result waits, until it is full.
// ----------------------------------------------------------------------------
module laplacian_tridiagonal_solver #(
	parameter int MAX_LEN = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // [31:0] sample, [41:32] read_index
	input  logic        s_tlast,   // final_sample
	input  logic        s_tuser,   // mode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [87:0] m_tdata,   // [63:0] value, [73:64] element_index, [84:74] vector_length
	output logic [1:0]  m_tuser    // kind
);

	logic          cmd_valid;
	logic          cmd_ready;
	lts_pkg::cmd_t cmd;

	// Request intake and queue.
	lts_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.s_tuser   (s_tuser),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd)
	);

	// Solve sequencer and readback.
	lts_back #(
		.MAX_LEN (MAX_LEN)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

endmodule

### verif/laplacian_tridiagonal_solver_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// laplacian_tridiagonal_solver_test: self-checking bench for the Thomas solver
// Streams load and read requests into the solver and predicts every result
// with its own fixed-point model of the pivot recurrence and the two sweeps.
// Results are compared field by field in order. The sender idles and the
// receiver stalls at random in several phases, including one long hold-off.
// ----------------------------------------------------------------------------
module laplacian_tridiagonal_solver_test;

	localparam logic MODE_LOAD = 1'b0;
	localparam logic MODE_READ = 1'b1;
	localparam int VEC_DEPTH = 1024;

	// Predictor of the solver plus the queue of results it expects.
	class solver_scoreboard;
		typedef struct {
			logic [1:0]  kind;
			logic [63:0] value;
			logic [9:0]  index;
			logic [10:0] length;
		} result_t;

		logic [31:0] pivots[VEC_DEPTH];
		logic [63:0] xs[VEC_DEPTH];
		int unsigned loaded;
		int unsigned solved_len;
		bit          solved;
		result_t     pending_results[$];
		int          errors;

		function logic [63:0] clamp_add(logic [63:0] a, logic [63:0] b);
			logic [63:0] s;
			s = a + b;
			if (a[63] == b[63] && s[63] != a[63])
				return a[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
			return s;
		endfunction

		// Q48.16 divided by a Q2.30 pivot, truncated toward zero.
		function logic [63:0] divide_by_pivot(logic [63:0] x, logic [31:0] d);
			logic [63:0] mag, dv, q;
			mag = x[63] ? -x : x;
			dv = (d < lts_pkg::Q30_ONE) ? {32'd0, lts_pkg::Q30_ONE} : {32'd0, d};
			q = ((mag / dv) << 30) + (((mag % dv) << 30) / dv);
			return x[63] ? -q : q;
		endfunction

		function logic [31:0] following_pivot(logic [31:0] d);
			logic [63:0] dv, num;
			dv = (d < lts_pkg::Q30_ONE) ? {32'd0, lts_pkg::Q30_ONE} : {32'd0, d};
			num = 2 * dv - {32'd0, lts_pkg::Q30_ONE};
			return 32'((num << 30) / dv);
		endfunction

		function void thomas_solve(int unsigned n);
			pivots[0] = lts_pkg::Q30_TWO;
			for (int i = 1; i < n; i++) begin
				pivots[i] = following_pivot(pivots[i - 1]);
				xs[i] = clamp_add(xs[i], divide_by_pivot(xs[i - 1], pivots[i - 1]));
			end
			xs[n - 1] = divide_by_pivot(xs[n - 1], pivots[n - 1]);
			for (int i = n - 1; i > 0; i--)
				xs[i - 1] = divide_by_pivot(clamp_add(xs[i - 1], xs[i]), pivots[i - 1]);
		endfunction

		function void note_request(logic mode, logic [31:0] smp, logic fin, logic [9:0] idx);
			result_t r;
			if (mode == MODE_LOAD) begin
				if (loaded == 0) begin
					solved = 0;
					solved_len = 0;
				end
				if (loaded < VEC_DEPTH) begin
					xs[loaded] = {{32{smp[31]}}, smp};
					loaded++;
				end
				if (!fin)
					return;
				thomas_solve(loaded);
				solved_len = loaded;
				solved = 1;
				loaded = 0;
				r.kind = lts_pkg::KIND_DONE;
				r.value = '0;
				r.index = '0;
			end else begin
				if (solved && idx < solved_len) begin
					r.kind = lts_pkg::KIND_DATA;
					r.value = xs[idx];
				end else begin
					r.kind = lts_pkg::KIND_INVALID;
					r.value = '0;
				end
				r.index = idx;
			end
			r.length = 11'(solved_len);
			pending_results.push_back(r);
		endfunction

		function void check_result(logic [1:0] kind, logic [63:0] value, logic [9:0] idx,
				logic [10:0] len);
			result_t e;
			if (pending_results.size() == 0) begin
				$error("unexpected result: kind %0d value %h", kind, value);
				errors++;
				return;
			end
			e = pending_results.pop_front();
			if (kind !== e.kind) begin
				$error("kind: expected %0d, got %0d", e.kind, kind);
				errors++;
			end
			if (value !== e.value) begin
				$error("value: expected %h, got %h", e.value, value);
				errors++;
			end
			if (idx !== e.index) begin
				$error("element_index: expected %0d, got %0d", e.index, idx);
				errors++;
			end
			if (len !== e.length) begin
				$error("vector_length: expected %0d, got %0d", e.length, len);
				errors++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [47:0] s_tdata;   // [31:0] sample, [41:32] read_index
	logic        s_tlast;   // final_sample
	logic        s_tuser;   // mode
	logic        m_tvalid;
	logic        m_tready;
	logic [87:0] m_tdata;   // [63:0] value, [73:64] element_index, [84:74] vector_length
	logic [1:0]  m_tuser;   // kind

	solver_scoreboard board = new();
	int idle_pct;
	int stall_pct;
	bit hold_request;
	int hold_left;

	laplacian_tridiagonal_solver dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.s_tlast(s_tlast), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#1_200_000_000;
		$display("laplacian_tridiagonal_solver_test: done, errors");
		$finish;
	end

	// Receiver: random stalls, plus a long hold-off when requested.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			hold_left = 0;
		end else begin
			if (hold_request) begin
				hold_left = 400;
				hold_request = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	// Results are stable between the falling edge and the accepting edge.
	always @(negedge clk)
		if (arst_n && m_tvalid && m_tready)
			board.check_result(m_tuser, m_tdata[63:0], m_tdata[73:64], m_tdata[84:74]);

	// Offers one request and returns at the edge that accepts it.
	task automatic send_request(logic mode, logic [31:0] smp, logic fin, logic [9:0] idx);
		if ($urandom_range(99) < idle_pct) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= mode;
		s_tlast  <= fin;
		s_tdata  <= {6'd0, idx, smp};
		@(negedge clk);
		while (!s_tready) @(negedge clk);
		board.note_request(mode, smp, fin, idx);
		@(posedge clk);
	endtask

	function automatic logic [31:0] pick_sample();
		case ($urandom_range(4))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'($signed($urandom_range(0, 2 << 16)) - (1 << 16));
			default: return $urandom;
		endcase
	endfunction

	task automatic load_vector(int len);
		for (int i = 0; i < len; i++) begin
			// A read in the middle of loading must report invalid; one before the first sample may still read the last solution.
			if ($urandom_range(9) == 0)
				send_request(MODE_READ, $urandom, 1'b0, 10'($urandom_range(0, 15)));
			send_request(MODE_LOAD, pick_sample(), i == len - 1, 10'($urandom));
		end
	endtask

	task automatic read_back(int len, int count);
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(5) == 0)
				send_request(MODE_READ, $urandom, 1'($urandom), 10'($urandom));
			else
				send_request(MODE_READ, $urandom, 1'($urandom),
					10'($urandom_range(0, len - 1)));
		end
	endtask

	// Stops offering requests and waits for every expected result.
	task automatic drain();
		s_tvalid <= 1'b0;
		while (board.pending_results.size() != 0) @(posedge clk);
	endtask

	initial begin
		int len;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tlast = 1'b0;
		s_tuser = 1'b0;
		idle_pct = 0;
		stall_pct = 0;
		hold_request = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: reads before any solve, a one-element solve, extremes.
		send_request(MODE_READ, 32'd0, 1'b0, 10'd0);
		send_request(MODE_READ, 32'hFFFF_FFFF, 1'b1, 10'd1023);
		send_request(MODE_LOAD, 32'h7FFF_FFFF, 1'b1, 10'd0);
		send_request(MODE_READ, 32'd0, 1'b0, 10'd0);
		send_request(MODE_READ, 32'd0, 1'b0, 10'd1);
		send_request(MODE_LOAD, 32'h8000_0000, 1'b0, 10'd1023);
		send_request(MODE_READ, 32'd0, 1'b0, 10'd0);
		send_request(MODE_LOAD, 32'h7FFF_FFFF, 1'b0, 10'd0);
		send_request(MODE_LOAD, 32'h0001_0000, 1'b0, 10'd0);
		send_request(MODE_LOAD, 32'h8000_0000, 1'b1, 10'd0);
		for (int i = 0; i < 5; i++)
			send_request(MODE_READ, 32'd0, 1'b0, 10'(i));
		send_request(MODE_READ, 32'd0, 1'b0, 10'd1023);

		// Buffer full: the samples past the buffer depth are dropped.
		for (int i = 0; i < VEC_DEPTH + 3; i++)
			send_request(MODE_LOAD, pick_sample(), i == VEC_DEPTH + 2, 10'd0);
		send_request(MODE_READ, 32'd0, 1'b0, 10'd1023);
		send_request(MODE_READ, 32'd0, 1'b0, 10'd0);
		read_back(VEC_DEPTH, 6);
		drain();

		// Random phases with different idling mixes.
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 65; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 65; end
				default: begin idle_pct = 21; stall_pct = 21; end
			endcase
			for (int v = 0; v < 4; v++) begin
				len = ($urandom_range(7) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 6);
				load_vector(len);
				// Long hold-off while reads keep coming, so the queue fills up.
				if (phase == 2 && v == 1) begin
					hold_request = 1;
					read_back(len, 10);
				end
				read_back(len, $urandom_range(2, 12));
			end
		end

		drain();
		repeat (50) @(posedge clk);
		if (board.errors == 0)
			$display("laplacian_tridiagonal_solver_test: done, clean");
		else
			$display("laplacian_tridiagonal_solver_test: done, errors");
		$finish;
	end

endmodule
